>>> hw/rtl/rmp_pkg.sv
// shared types and constants for the running median pairs unit
package rmp_pkg;

    localparam int ValueWidth = 16;
    localparam int GroupSize  = 32;
    localparam int AddrWidth  = 3;

    localparam logic [AddrWidth-1:0] RegSeedValue = 3'd0;
    localparam logic [ValueWidth-1:0] SeedReset   = 16'd500;

    typedef struct packed {
        logic                  restart;
        logic [ValueWidth-1:0] first_value;
        logic [ValueWidth-1:0] second_value;
    } in_item_t;

    typedef struct packed {
        logic [ValueWidth-1:0] median;
        logic                  overflow;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic ins_a;
        logic ins_b;
        logic red1;
        logic red2;
    } rmp_cmd_t;

    typedef struct packed {
        logic full;
    } rmp_status_t;

endpackage

>>> hw/rtl/rmp_datapath.sv
// sorted insertion chain, median marker and median readout tree
module rmp_datapath
    import rmp_pkg::*;
#(
    parameter int CAPACITY = 1023
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rmp_cmd_t              cmd,
    output rmp_status_t           status,
    input  in_item_t              in_item,
    input  logic [ValueWidth-1:0] seed_value,
    output out_item_t             out_item
);

    localparam int Groups = (CAPACITY + GroupSize - 1) / GroupSize;

    logic [ValueWidth-1:0] cell_reg [CAPACITY];
    logic [CAPACITY-1:0]   valid_reg;
    logic [CAPACITY-1:0]   valid_next;
    logic [CAPACITY-1:0]   mark_reg;
    logic [CAPACITY-1:0]   mark_next;
    logic [ValueWidth-1:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0]   cell_we;
    logic [CAPACITY-1:0]   gt;
    logic [ValueWidth-1:0] ins_val;
    logic                  ins_en;
    logic                  seed_now;
    in_item_t              item_reg;
    logic                  ovf_reg;
    logic [ValueWidth-1:0] grp_reg [Groups];
    logic [ValueWidth-1:0] grp_next [Groups];
    logic [ValueWidth-1:0] med_next;
    out_item_t             out_reg;

    assign status.full = valid_reg[CAPACITY-2];
    assign seed_now    = cmd.load && (in_item.restart || !valid_reg[0]);
    assign ins_val     = cmd.ins_b ? item_reg.second_value : item_reg.first_value;
    assign ins_en      = (cmd.ins_a && !status.full) || cmd.ins_b;

    // each cell compares against the new value and takes its neighbor on a shift
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++) begin
            gt[i] = valid_reg[i] && (cell_reg[i] > ins_val);
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == 0) begin
                cell_next[i] = ins_val;
                cell_we[i]   = valid_reg[i] ? gt[i] : 1'b1;
            end else begin
                cell_next[i] = gt[i-1] ? cell_reg[i-1] : ins_val;
                cell_we[i]   = valid_reg[i] ? gt[i] : valid_reg[i-1];
            end
        end
        valid_next = {valid_reg[CAPACITY-2:0], 1'b1};
        mark_next  = {mark_reg[CAPACITY-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (seed_now && i == 0) begin
                cell_reg[i] <= seed_value;
            end else if (ins_en && cell_we[i]) begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            mark_reg  <= '0;
        end else if (seed_now) begin
            valid_reg <= {{(CAPACITY-1){1'b0}}, 1'b1};
            mark_reg  <= {{(CAPACITY-1){1'b0}}, 1'b1};
        end else begin
            if (ins_en) begin
                valid_reg <= valid_next;
            end
            if (cmd.ins_b) begin
                mark_reg <= mark_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            item_reg <= in_item;
        end
        if (cmd.ins_a) begin
            ovf_reg <= status.full;
        end
    end

    // two level and-or readout of the marked cell
    always_comb
    begin
        for (int g = 0; g < Groups; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < GroupSize; j++) begin
                if (g * GroupSize + j < CAPACITY) begin
                    grp_next[g] = grp_next[g]
                        | (cell_reg[g * GroupSize + j]
                           & {ValueWidth{mark_reg[g * GroupSize + j]}});
                end
            end
        end
        med_next = '0;
        for (int g = 0; g < Groups; g++) begin
            med_next = med_next | grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.red1) begin
            for (int g = 0; g < Groups; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
        if (cmd.red2) begin
            out_reg.median   <= med_next;
            out_reg.overflow <= ovf_reg;
        end
    end

    assign out_item = out_reg;

endmodule

>>> hw/rtl/rmp_ctrl.sv
// sequencer for accept, two insertions (none when the set is full), readout and result handoff
module rmp_ctrl
    import rmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  rmp_status_t status,
    output rmp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INS_A = 5'b00010,
        S_INS_B = 5'b00100,
        S_RED1  = 5'b01000,
        S_RED2  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_INS_A;
                end
            end
            S_INS_A:
            begin
                cmd.ins_a  = 1'b1;
                state_next = status.full ? S_RED1 : S_INS_B;
            end
            S_INS_B:
            begin
                cmd.ins_b  = 1'b1;
                state_next = S_RED1;
            end
            S_RED1:
            begin
                cmd.red1   = 1'b1;
                state_next = S_RED2;
            end
            S_RED2:
            begin
                if (out_free) begin
                    cmd.red2       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/running_median_pairs_unit.sv
// top level of the running median pairs unit
// result: each item passes the two insertions (none when the set is full), then the readout levels;
// a new item is accepted only after the previous result has left RED2; the insertion chain takes one value
// per cycle and the median readout tree adds two registered levels
// reset: asynchronous active low; the set is empty and seed_value returns to 500,
// so the first item seeds the set
module running_median_pairs_unit
    import rmp_pkg::*;
#(
    parameter int CAPACITY = 1023
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input item channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    // result item channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    rmp_cmd_t              cmd;
    rmp_status_t           status;
    logic [ValueWidth-1:0] seed_reg;
    logic                  cfg_wr;

    // seed register, written in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == RegSeedValue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seed_reg <= SeedReset;
        end else if (cfg_wr) begin
            seed_reg <= pwdata[ValueWidth-1:0];
        end
    end

    // only the seed register reads back non-zero
    always_comb
    begin
        prdata = '0;
        if (paddr == RegSeedValue) begin
            prdata = {{(32-ValueWidth){1'b0}}, seed_reg};
        end
    end

    // sequencer: accept, insert first, insert second (no insertion when the set is full), two readout levels
    rmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // sorted cell chain with a one-hot marker on the middle element
    rmp_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_item    (in_item),
        .seed_value (seed_reg),
        .out_item   (out_item)
    );

endmodule
